@@ sv/bppsu_pkg.sv @@
package bppsu_pkg;

   // Row and column geometry
   localparam int ROWS      = 16;
   localparam int WORD_W    = 16;
   localparam int COLUMNS   = 1024;            // power of two: index is the low bits
   localparam int COL_W     = 10;
   localparam int COL_IDX_W = $clog2(COLUMNS);

   // Counter widths and limits
   localparam int CNT_W   = 5;
   localparam int TRIES_W = 4;
   localparam int SUM_W   = CNT_W + 1;

   localparam logic [CNT_W-1:0]   COUNT_MAX  = CNT_W'(31);
   localparam logic [CNT_W-1:0]   INIT_VIOL  = CNT_W'(1);
   localparam logic [CNT_W-1:0]   BEST_INIT  = (ROWS + 1 > 31) ? COUNT_MAX : CNT_W'(ROWS + 1);
   localparam logic [TRIES_W-1:0] INIT_TRIES = TRIES_W'(3);
   localparam logic [TRIES_W-1:0] TRIES_RST  = TRIES_W'(3);

   localparam logic [WORD_W-1:0] ROW_MASK =
      (ROWS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << ROWS) - 64'd1);

   // Operation codes
   localparam logic OP_INIT  = 1'b0;
   localparam logic OP_PIVOT = 1'b1;

   // Per-column state kept in the column memory
   typedef struct packed {
      logic [WORD_W-1:0]  passive;
      logic [CNT_W-1:0]   viol;
      logic [CNT_W-1:0]   best;
      logic [TRIES_W-1:0] tries;
   } col_state_type;

   // One result word
   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [WORD_W-1:0] passive;
      logic [WORD_W-1:0] nonopt;
      logic [WORD_W-1:0] infeas;
      logic [CNT_W-1:0]  viol;
      logic              unsettled;
      logic              all_zero;
   } out_word_type;

   // Number of set bits in one row word
   function automatic logic [CNT_W-1:0] count_ones(input logic [WORD_W-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int k = 0; k < WORD_W; k++) begin
         n = n + CNT_W'(v[k]);
      end
      return n;
   endfunction

   // One-hot of the highest set bit, zero when none
   function automatic logic [WORD_W-1:0] highest_bit(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] b;
      b = '0;
      for (int k = 0; k < WORD_W; k++) begin
         if (v[k]) begin
            b = WORD_W'(1) << k;
         end
      end
      return b;
   endfunction

endpackage

@@ sv/block_pivot_passive_set_update_unit.sv @@
// Channel   Ports                              Direction  Handshake
// req       req_op .. req_y_negative           in         req_valid / req_stall
// rsp       rsp_out_column .. rsp_all_zero     out        rsp_valid / rsp_stall
// csr       csr_wr_data                        in         csr_wr_en, no wait
//
// One word per cycle in while req_stall is low; a result passes through read, mark/count,
// update/write-back, then the output register. The column memory has one read
// and one write port; back-to-back words on one column are served by forwarding.
// Reset clears control and sets backup_tries to 3; column state is undefined
// until a column sees an init word. A stalled result parks in a skid register,
// and the pipeline holds only when that skid register is full.
module block_pivot_passive_set_update_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [bppsu_pkg::TRIES_W-1:0]  csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [bppsu_pkg::COL_W-1:0]    req_column,
   input  logic [bppsu_pkg::WORD_W-1:0]   req_x_positive,
   input  logic [bppsu_pkg::WORD_W-1:0]   req_x_zero,
   input  logic [bppsu_pkg::WORD_W-1:0]   req_x_negative,
   input  logic [bppsu_pkg::WORD_W-1:0]   req_y_negative,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bppsu_pkg::COL_W-1:0]    rsp_out_column,
   output logic [bppsu_pkg::WORD_W-1:0]   rsp_passive_bits,
   output logic [bppsu_pkg::WORD_W-1:0]   rsp_nonoptimal_bits,
   output logic [bppsu_pkg::WORD_W-1:0]   rsp_infeasible_bits,
   output logic [bppsu_pkg::CNT_W-1:0]    rsp_violations,
   output logic                           rsp_column_unsettled,
   output logic                           rsp_all_zero
);
   import bppsu_pkg::*;

   // Config register
   logic [TRIES_W-1:0] backup_tries_ff;

   // Column memory
   col_state_type state_mem [COLUMNS];

   // Stage 1: read data and word fields
   logic                  s1_valid_ff;
   logic                  s1_op_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic [WORD_W-1:0]     s1_xpos_ff;
   logic [WORD_W-1:0]     s1_xzero_ff;
   logic [WORD_W-1:0]     s1_xneg_ff;
   logic [WORD_W-1:0]     s1_yneg_ff;
   col_state_type         rd_ff;

   // Stage 2: marks and counts
   logic                  s2_valid_ff;
   logic                  s2_op_ff;
   logic [COL_W-1:0]      s2_col_ff;
   logic [WORD_W-1:0]     s2_xpos_ff;
   logic                  s2_allz_ff;
   logic [WORD_W-1:0]     s2_nonopt_ff;
   logic [WORD_W-1:0]     s2_infeas_ff;
   logic [CNT_W-1:0]      s2_cnt_ff;
   col_state_type         s2_old_ff;

   // Last write, for reads that raced it
   logic                  wb_valid_ff;
   logic [COL_IDX_W-1:0]  wb_idx_ff;
   col_state_type         wb_state_ff;

   // Output and skid registers
   logic                  rsp_valid_ff, rsp_valid_in;
   out_word_type          rsp_word_ff, rsp_word_in;
   logic                  skid_valid_ff, skid_valid_in;
   out_word_type          skid_word_ff, skid_word_in;

   logic                  en;
   logic                  push;
   logic                  take;
   logic [COL_IDX_W-1:0]  s1_idx, s2_idx;
   col_state_type         s1_state;
   col_state_type         s2_new;
   out_word_type          s2_word;
   logic [WORD_W-1:0]     s1_nonopt, s1_infeas;
   logic [SUM_W-1:0]      s1_sum;
   logic [CNT_W-1:0]      s1_cnt;
   logic                  s1_allz;

   // Pipeline moves unless the skid register is occupied
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign push      = en && s2_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   assign s1_idx = s1_col_ff[COL_IDX_W-1:0];
   assign s2_idx = s2_col_ff[COL_IDX_W-1:0];

   // Config write
   always_ff @(posedge clock) begin
      if (reset) begin
         backup_tries_ff <= TRIES_RST;
      end else if (csr_wr_en) begin
         backup_tries_ff <= csr_wr_data;
      end
   end

   // Stage 1 capture and memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff    <= req_op;
         s1_col_ff   <= req_column;
         s1_xpos_ff  <= req_x_positive;
         s1_xzero_ff <= req_x_zero;
         s1_xneg_ff  <= req_x_negative;
         s1_yneg_ff  <= req_y_negative;
         rd_ff       <= state_mem[req_column[COL_IDX_W-1:0]];
      end
   end

   // Stage 1: newest state of the column, then marks and count
   always_comb begin
      if (s2_valid_ff && s2_idx == s1_idx) begin
         s1_state = s2_new;
      end else if (wb_valid_ff && wb_idx_ff == s1_idx) begin
         s1_state = wb_state_ff;
      end else begin
         s1_state = rd_ff;
      end

      s1_nonopt = '0;
      s1_infeas = '0;
      if (s1_op_ff == OP_PIVOT && s1_state.viol != '0) begin
         s1_nonopt = s1_yneg_ff & ~s1_state.passive & ROW_MASK;
         s1_infeas = s1_xneg_ff & s1_state.passive & ROW_MASK;
      end
      s1_sum = SUM_W'(count_ones(s1_nonopt)) + SUM_W'(count_ones(s1_infeas));
      s1_cnt = (s1_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : s1_sum[CNT_W-1:0];
      s1_allz = (s1_op_ff == OP_INIT) && ((s1_xzero_ff & ROW_MASK) == ROW_MASK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_op_ff     <= s1_op_ff;
         s2_col_ff    <= s1_col_ff;
         s2_xpos_ff   <= s1_xpos_ff;
         s2_allz_ff   <= s1_allz;
         s2_nonopt_ff <= s1_nonopt;
         s2_infeas_ff <= s1_infeas;
         s2_cnt_ff    <= s1_cnt;
         s2_old_ff    <= s1_state;
      end
   end

   // Stage 2: set exchange and new column state
   always_comb begin
      s2_new = s2_old_ff;
      if (s2_op_ff == OP_INIT) begin
         s2_new.passive = s2_xpos_ff & ROW_MASK;
         s2_new.viol    = INIT_VIOL;
         s2_new.best    = BEST_INIT;
         s2_new.tries   = INIT_TRIES;
      end else begin
         s2_new.viol = s2_cnt_ff;
         if (s2_cnt_ff != '0) begin
            if (s2_cnt_ff < s2_old_ff.best) begin
               s2_new.tries   = backup_tries_ff;
               s2_new.best    = s2_cnt_ff;
               s2_new.passive = (s2_old_ff.passive | s2_nonopt_ff) & ~s2_infeas_ff
                                & ROW_MASK;
            end else if (s2_old_ff.tries != '0) begin
               s2_new.tries   = s2_old_ff.tries - TRIES_W'(1);
               s2_new.passive = (s2_old_ff.passive | s2_nonopt_ff) & ~s2_infeas_ff
                                & ROW_MASK;
            end else begin
               s2_new.passive = (s2_old_ff.passive
                                 ^ highest_bit(s2_nonopt_ff | s2_infeas_ff)) & ROW_MASK;
            end
         end
      end

      s2_word.column    = s2_col_ff;
      s2_word.passive   = s2_new.passive;
      s2_word.nonopt    = s2_nonopt_ff;
      s2_word.infeas    = s2_infeas_ff;
      s2_word.viol      = s2_new.viol;
      s2_word.unsettled = (s2_new.viol != '0);
      s2_word.all_zero  = s2_allz_ff;
   end

   // Write-back and last-write record
   always_ff @(posedge clock) begin
      if (push) begin
         state_mem[s2_idx] <= s2_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (push) begin
         wb_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         wb_idx_ff   <= s2_idx;
         wb_state_ff <= s2_new;
      end
   end

   // Output register with skid
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push;
            rsp_word_in  = s2_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = s2_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_column       = rsp_word_ff.column;
   assign rsp_passive_bits     = rsp_word_ff.passive;
   assign rsp_nonoptimal_bits  = rsp_word_ff.nonopt;
   assign rsp_infeasible_bits  = rsp_word_ff.infeas;
   assign rsp_violations       = rsp_word_ff.viol;
   assign rsp_column_unsettled = rsp_word_ff.unsettled;
   assign rsp_all_zero         = rsp_word_ff.all_zero;

endmodule
